### sv/circle_obb_contact_unit_assert.svh
// assertion macros for the circle/box contact unit
`ifndef CIRCLE_OBB_CONTACT_UNIT_ASSERT_SVH
`define CIRCLE_OBB_CONTACT_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define COC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("circle_obb_contact_unit: check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define COC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("circle_obb_contact_unit: check failed");

`endif

### sv/coc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package coc_pkg;

  // fixed field widths
  localparam int COORD_W = 32;
  localparam int LEN_W   = 31;
  localparam int TRIG_W  = 16;

  // width of a rotation product sum (16 x 33 bit products, plus one)
  localparam int ROT_W = 50;

  // integer square root: one step per result bit over a 64 bit radicand
  localparam int SQ_W     = 64;
  localparam int SQ_STEPS = 32;
  localparam int DSQ_W    = 63;
  localparam int RSQ_W    = 62;

endpackage

`default_nettype wire

### sv/circle_obb_contact_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// circle versus oriented box contact unit
// input channel: in_valid_i / in_stall_o carry one transaction per circle/box
// pair (Q16.16 coordinates, Q1.14 cos/sin of the box rotation). output channel:
// out_valid_o / out_stall_i carry one contact result per input transaction, in
// order: hit flag, world normal (Q1.14), penetration and world contact point.
// a miss reports all fields as zero.
// throughput: one transaction per cycle, no bubbles between items, except while
// out_stall_i holds a result at the output. the pipeline depth is set by the
// 32-step integer square root and the TRIG_FRAC_BITS+1 step quotient for the
// unit normal, one step per pipeline stage.
// stall: the whole pipeline advances together; while the output holds a result
// and out_stall_i is high, every stage freezes and in_stall_o is raised, so no
// transaction is dropped or repeated. the input side sees the stall in the
// same cycle.
// reset: rst_ni clears all stage valid bits; in-flight transactions are
// discarded and no result appears until new input is accepted.

`include "circle_obb_contact_unit_assert.svh"

module circle_obb_contact_unit import coc_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int TRIG_FRAC_BITS  = 14
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic signed [COORD_W-1:0]  circle_center_x_i,
  input  wire logic signed [COORD_W-1:0]  circle_center_y_i,
  input  wire logic        [LEN_W-1:0]    radius_i,
  input  wire logic signed [COORD_W-1:0]  box_center_x_i,
  input  wire logic signed [COORD_W-1:0]  box_center_y_i,
  input  wire logic signed [TRIG_W-1:0]   box_cos_i,
  input  wire logic signed [TRIG_W-1:0]   box_sin_i,
  input  wire logic        [LEN_W-1:0]    half_x_i,
  input  wire logic        [LEN_W-1:0]    half_y_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            hit_o,
  output logic signed [TRIG_W-1:0]        normal_x_o,
  output logic signed [TRIG_W-1:0]        normal_y_o,
  output logic        [LEN_W-1:0]         penetration_o,
  output logic signed [COORD_W-1:0]       contact_x_o,
  output logic signed [COORD_W-1:0]       contact_y_o
);

  // local coordinate width after the rounding shift
  localparam int LW  = ROT_W - TRIG_FRAC_BITS;
  // quotient bits of the unit normal (magnitude up to 2^TRIG_FRAC_BITS)
  localparam int QW  = TRIG_FRAC_BITS + 1;
  // signed normal width
  localparam int NW  = TRIG_FRAC_BITS + 2;
  // dividend width: (|diff| << frac) + dist/2
  localparam int DW  = LEN_W + 1 + TRIG_FRAC_BITS;
  // normal rotation product width and rounded sum width
  localparam int MW  = TRIG_W + NW;
  localparam int MRW = MW + 1 - TRIG_FRAC_BITS;
  // contact rotation product width
  localparam int CPW = TRIG_W + COORD_W;
  // distances below this count as the centre lying inside the box (1e-6)
  localparam int NEAR_LIMIT = ((1 << COORD_FRAC_BITS) + 999999) / 1000000;

  localparam logic signed [ROT_W-1:0] RND_HALF =
    ROT_W'(64'd1 << (TRIG_FRAC_BITS - 1));
  localparam logic signed [MW:0] MRND_HALF = (MW + 1)'(64'd1 << (TRIG_FRAC_BITS - 1));
  localparam logic signed [NW-1:0] NORM_ONE = NW'(64'd1 << TRIG_FRAC_BITS);

  // stage map
  localparam int ST_A   = 0;                 // centre difference
  localparam int ST_B   = 1;                 // inverse rotation products
  localparam int ST_C   = 2;                 // local centre, rounded
  localparam int ST_D   = 3;                 // clamp to half extents
  localparam int ST_E   = 4;                 // difference, contact products
  localparam int ST_F   = 5;                 // magnitudes, early miss, face gaps
  localparam int ST_G   = 6;                 // squares, world contact, inside case
  localparam int ST_H   = 7;                 // squared distance
  localparam int ST_I   = 8;                 // radius compare
  localparam int ST_SQ  = 9;                 // square root steps
  localparam int ST_J   = ST_SQ + SQ_STEPS;  // distance, dividend setup
  localparam int ST_DV  = ST_J + 1;          // quotient steps
  localparam int ST_K   = ST_DV + QW;        // normal select
  localparam int ST_L   = ST_K + 1;          // normal rotation products
  localparam int ST_M   = ST_L + 1;          // normal rotation sums
  localparam int ST_N   = ST_M + 1;          // saturate, output register
  localparam int NSTAGE = ST_N + 1;

  typedef struct packed {
    logic signed [TRIG_W-1:0]  c;
    logic signed [TRIG_W-1:0]  s;
    logic        [LEN_W-1:0]   r;
    logic        [LEN_W-1:0]   hx;
    logic        [LEN_W-1:0]   hy;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W:0]   ddx;
    logic signed [COORD_W:0]   ddy;
    logic signed [COORD_W+TRIG_W:0] p1;
    logic signed [COORD_W+TRIG_W:0] p2;
    logic signed [COORD_W+TRIG_W:0] p3;
    logic signed [COORD_W+TRIG_W:0] p4;
    logic signed [LW-1:0]      lx;
    logic signed [LW-1:0]      ly;
    logic        [LW-1:0]      alx;
    logic        [LW-1:0]      aly;
    logic signed [COORD_W-1:0] clx;
    logic signed [COORD_W-1:0] cly;
    logic signed [LW-1:0]      dfx;
    logic signed [LW-1:0]      dfy;
    logic signed [CPW-1:0]     q1;
    logic signed [CPW-1:0]     q2;
    logic signed [CPW-1:0]     q3;
    logic signed [CPW-1:0]     q4;
    logic signed [LW-1:0]      wlx;
    logic signed [LW-1:0]      wly;
    logic        [LEN_W-1:0]   mx;
    logic        [LEN_W-1:0]   my;
    logic                      miss;
    logic signed [LW:0]        fx;
    logic signed [LW:0]        fy;
    logic        [RSQ_W-1:0]   sqx;
    logic        [RSQ_W-1:0]   sqy;
    logic        [RSQ_W-1:0]   rsq;
    logic signed [COORD_W-1:0] wx;
    logic signed [COORD_W-1:0] wy;
    logic signed [NW-1:0]      near_nx;
    logic signed [NW-1:0]      near_ny;
    logic        [LEN_W-1:0]   near_pen;
    logic        [DSQ_W-1:0]   dsq;
    logic        [SQ_W-1:0]    sqn;
    logic        [SQ_W-1:0]    sqres;
    logic        [LEN_W-1:0]   root;
    logic                      near;
    logic        [QW-1:0]      dvx_lo;
    logic        [QW-1:0]      dvy_lo;
    logic        [LEN_W-1:0]   remx;
    logic        [LEN_W-1:0]   remy;
    logic        [QW-1:0]      qx;
    logic        [QW-1:0]      qy;
    logic        [LEN_W-1:0]   pen;
    logic signed [NW-1:0]      nx;
    logic signed [NW-1:0]      ny;
    logic signed [MW-1:0]      m1;
    logic signed [MW-1:0]      m2;
    logic signed [MW-1:0]      m3;
    logic signed [MW-1:0]      m4;
    logic signed [MRW-1:0]     rnx;
    logic signed [MRW-1:0]     rny;
    logic signed [TRIG_W-1:0]  wnx;
    logic signed [TRIG_W-1:0]  wny;
  } item_t;

  item_t pipe_q [NSTAGE];
  item_t pipe_d [NSTAGE];
  logic  [NSTAGE-1:0] vld_q;
  logic  adv;

  // the whole pipe moves unless a finished result is held at the output
  assign adv        = !vld_q[ST_N] || !out_stall_i;
  assign in_stall_o = !adv;

  always_comb begin
    logic signed [ROT_W-1:0] sum_a;
    logic signed [ROT_W-1:0] sum_b;
    logic signed [LW-1:0]    hxs;
    logic signed [LW-1:0]    hys;
    logic signed [LW-1:0]    cx_w;
    logic signed [LW-1:0]    cy_w;
    logic        [LW-1:0]    mag_x;
    logic        [LW-1:0]    mag_y;
    logic signed [LW:0]      wsx;
    logic signed [LW:0]      wsy;
    logic signed [LW+1:0]    pn;
    logic        [SQ_W-1:0]  sq_bit;
    logic        [SQ_W-1:0]  sq_trial;
    logic        [DW-1:0]    dvx;
    logic        [DW-1:0]    dvy;
    logic        [LEN_W:0]   shx;
    logic        [LEN_W:0]   shy;
    logic signed [LEN_W:0]   pf;
    logic signed [NW-1:0]    qsx;
    logic signed [NW-1:0]    qsy;
    logic signed [MW:0]      msx;
    logic signed [MW:0]      msy;

    // stage A: take the transaction, centre difference
    pipe_d[ST_A]     = '0;
    pipe_d[ST_A].c   = box_cos_i;
    pipe_d[ST_A].s   = box_sin_i;
    pipe_d[ST_A].r   = radius_i;
    pipe_d[ST_A].hx  = half_x_i;
    pipe_d[ST_A].hy  = half_y_i;
    pipe_d[ST_A].bx  = box_center_x_i;
    pipe_d[ST_A].by  = box_center_y_i;
    pipe_d[ST_A].ddx = (COORD_W + 1)'(circle_center_x_i) - (COORD_W + 1)'(box_center_x_i);
    pipe_d[ST_A].ddy = (COORD_W + 1)'(circle_center_y_i) - (COORD_W + 1)'(box_center_y_i);

    // stage B: products of the inverse rotation
    pipe_d[ST_B]    = pipe_q[ST_A];
    pipe_d[ST_B].p1 = pipe_q[ST_A].c * pipe_q[ST_A].ddx;
    pipe_d[ST_B].p2 = pipe_q[ST_A].s * pipe_q[ST_A].ddy;
    pipe_d[ST_B].p3 = pipe_q[ST_A].c * pipe_q[ST_A].ddy;
    pipe_d[ST_B].p4 = pipe_q[ST_A].s * pipe_q[ST_A].ddx;

    // stage C: round to nearest, ties up (floor of value plus half)
    pipe_d[ST_C] = pipe_q[ST_B];
    sum_a = ROT_W'(pipe_q[ST_B].p1) + ROT_W'(pipe_q[ST_B].p2) + RND_HALF;
    sum_b = ROT_W'(pipe_q[ST_B].p3) - ROT_W'(pipe_q[ST_B].p4) + RND_HALF;
    pipe_d[ST_C].lx = sum_a[ROT_W-1:TRIG_FRAC_BITS];
    pipe_d[ST_C].ly = sum_b[ROT_W-1:TRIG_FRAC_BITS];

    // stage D: clamp into the box
    pipe_d[ST_D] = pipe_q[ST_C];
    hxs = $signed(LW'(pipe_q[ST_C].hx));
    hys = $signed(LW'(pipe_q[ST_C].hy));
    if (pipe_q[ST_C].lx > hxs) begin
      cx_w = hxs;
    end else if (pipe_q[ST_C].lx < -hxs) begin
      cx_w = -hxs;
    end else begin
      cx_w = pipe_q[ST_C].lx;
    end
    if (pipe_q[ST_C].ly > hys) begin
      cy_w = hys;
    end else if (pipe_q[ST_C].ly < -hys) begin
      cy_w = -hys;
    end else begin
      cy_w = pipe_q[ST_C].ly;
    end
    pipe_d[ST_D].clx = cx_w[COORD_W-1:0];
    pipe_d[ST_D].cly = cy_w[COORD_W-1:0];

    // stage E: offset from clamped point, forward rotation of contact point
    pipe_d[ST_E]     = pipe_q[ST_D];
    pipe_d[ST_E].dfx = pipe_q[ST_D].lx - LW'(pipe_q[ST_D].clx);
    pipe_d[ST_E].dfy = pipe_q[ST_D].ly - LW'(pipe_q[ST_D].cly);
    pipe_d[ST_E].alx = pipe_q[ST_D].lx[LW-1] ? LW'(-pipe_q[ST_D].lx) : LW'(pipe_q[ST_D].lx);
    pipe_d[ST_E].aly = pipe_q[ST_D].ly[LW-1] ? LW'(-pipe_q[ST_D].ly) : LW'(pipe_q[ST_D].ly);
    pipe_d[ST_E].q1  = pipe_q[ST_D].c * pipe_q[ST_D].clx;
    pipe_d[ST_E].q2  = pipe_q[ST_D].s * pipe_q[ST_D].cly;
    pipe_d[ST_E].q3  = pipe_q[ST_D].s * pipe_q[ST_D].clx;
    pipe_d[ST_E].q4  = pipe_q[ST_D].c * pipe_q[ST_D].cly;

    // stage F: magnitudes, early miss on either axis, face gaps
    pipe_d[ST_F] = pipe_q[ST_E];
    mag_x = pipe_q[ST_E].dfx[LW-1] ? LW'(-pipe_q[ST_E].dfx) : LW'(pipe_q[ST_E].dfx);
    mag_y = pipe_q[ST_E].dfy[LW-1] ? LW'(-pipe_q[ST_E].dfy) : LW'(pipe_q[ST_E].dfy);
    pipe_d[ST_F].mx   = mag_x[LEN_W-1:0];
    pipe_d[ST_F].my   = mag_y[LEN_W-1:0];
    pipe_d[ST_F].miss = (mag_x >= LW'(pipe_q[ST_E].r)) || (mag_y >= LW'(pipe_q[ST_E].r));
    pipe_d[ST_F].fx   = $signed((LW + 1)'(pipe_q[ST_E].hx) - (LW + 1)'(pipe_q[ST_E].alx));
    pipe_d[ST_F].fy   = $signed((LW + 1)'(pipe_q[ST_E].hy) - (LW + 1)'(pipe_q[ST_E].aly));
    sum_a = ROT_W'(pipe_q[ST_E].q1) - ROT_W'(pipe_q[ST_E].q2) + RND_HALF;
    sum_b = ROT_W'(pipe_q[ST_E].q3) + ROT_W'(pipe_q[ST_E].q4) + RND_HALF;
    pipe_d[ST_F].wlx = sum_a[ROT_W-1:TRIG_FRAC_BITS];
    pipe_d[ST_F].wly = sum_b[ROT_W-1:TRIG_FRAC_BITS];

    // stage G: squares, world contact point, centre-inside normal and depth
    pipe_d[ST_G]     = pipe_q[ST_F];
    pipe_d[ST_G].sqx = pipe_q[ST_F].mx * pipe_q[ST_F].mx;
    pipe_d[ST_G].sqy = pipe_q[ST_F].my * pipe_q[ST_F].my;
    pipe_d[ST_G].rsq = pipe_q[ST_F].r * pipe_q[ST_F].r;
    wsx = (LW + 1)'(pipe_q[ST_F].bx) + (LW + 1)'(pipe_q[ST_F].wlx);
    wsy = (LW + 1)'(pipe_q[ST_F].by) + (LW + 1)'(pipe_q[ST_F].wly);
    if (wsx[LW:COORD_W-1] == '0 || wsx[LW:COORD_W-1] == '1) begin
      pipe_d[ST_G].wx = wsx[COORD_W-1:0];
    end else begin
      pipe_d[ST_G].wx = wsx[LW] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    if (wsy[LW:COORD_W-1] == '0 || wsy[LW:COORD_W-1] == '1) begin
      pipe_d[ST_G].wy = wsy[COORD_W-1:0];
    end else begin
      pipe_d[ST_G].wy = wsy[LW] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    // nearer face wins, ties go to the y face
    if (pipe_q[ST_F].fx < pipe_q[ST_F].fy) begin
      pipe_d[ST_G].near_nx = (pipe_q[ST_F].lx > 0) ? NORM_ONE : -NORM_ONE;
      pipe_d[ST_G].near_ny = '0;
      pn = (LW + 2)'($signed({1'b0, pipe_q[ST_F].r})) + (LW + 2)'(pipe_q[ST_F].fx);
    end else begin
      pipe_d[ST_G].near_nx = '0;
      pipe_d[ST_G].near_ny = (pipe_q[ST_F].ly > 0) ? NORM_ONE : -NORM_ONE;
      pn = (LW + 2)'($signed({1'b0, pipe_q[ST_F].r})) + (LW + 2)'(pipe_q[ST_F].fy);
    end
    if (pn[LW+1]) begin
      pipe_d[ST_G].near_pen = '0;
    end else if (|pn[LW:LEN_W]) begin
      pipe_d[ST_G].near_pen = '1;
    end else begin
      pipe_d[ST_G].near_pen = pn[LEN_W-1:0];
    end

    // stage H: squared distance
    pipe_d[ST_H]     = pipe_q[ST_G];
    pipe_d[ST_H].dsq = DSQ_W'(pipe_q[ST_G].sqx) + DSQ_W'(pipe_q[ST_G].sqy);

    // stage I: against squared radius, seed the root
    pipe_d[ST_I]       = pipe_q[ST_H];
    pipe_d[ST_I].miss  = pipe_q[ST_H].miss || (pipe_q[ST_H].dsq >= DSQ_W'(pipe_q[ST_H].rsq));
    pipe_d[ST_I].sqn   = SQ_W'(pipe_q[ST_H].dsq);
    pipe_d[ST_I].sqres = '0;

    // square root: one result bit per stage
    for (int k = 0; k < SQ_STEPS; k++) begin
      pipe_d[ST_SQ+k] = pipe_q[ST_SQ+k-1];
      sq_bit   = SQ_W'(1) << (SQ_W - 2 - 2 * k);
      sq_trial = pipe_q[ST_SQ+k-1].sqres + sq_bit;
      if (pipe_q[ST_SQ+k-1].sqn >= sq_trial) begin
        pipe_d[ST_SQ+k].sqn   = pipe_q[ST_SQ+k-1].sqn - sq_trial;
        pipe_d[ST_SQ+k].sqres = (pipe_q[ST_SQ+k-1].sqres >> 1) + sq_bit;
      end else begin
        pipe_d[ST_SQ+k].sqres = pipe_q[ST_SQ+k-1].sqres >> 1;
      end
    end

    // stage J: distance, outside depth, dividends for the unit normal
    pipe_d[ST_J]      = pipe_q[ST_J-1];
    pipe_d[ST_J].root = pipe_q[ST_J-1].sqres[LEN_W-1:0];
    pipe_d[ST_J].near = pipe_q[ST_J-1].sqres[LEN_W-1:0] < LEN_W'(NEAR_LIMIT);
    pf = $signed({1'b0, pipe_q[ST_J-1].r}) - $signed({1'b0, pipe_q[ST_J-1].sqres[LEN_W-1:0]});
    pipe_d[ST_J].pen = pf[LEN_W] ? '0 : pf[LEN_W-1:0];
    dvx = (DW'(pipe_q[ST_J-1].mx) << TRIG_FRAC_BITS) + DW'(pipe_q[ST_J-1].sqres[LEN_W-1:1]);
    dvy = (DW'(pipe_q[ST_J-1].my) << TRIG_FRAC_BITS) + DW'(pipe_q[ST_J-1].sqres[LEN_W-1:1]);
    pipe_d[ST_J].remx   = dvx[DW-1:QW];
    pipe_d[ST_J].remy   = dvy[DW-1:QW];
    pipe_d[ST_J].dvx_lo = dvx[QW-1:0];
    pipe_d[ST_J].dvy_lo = dvy[QW-1:0];
    pipe_d[ST_J].qx     = '0;
    pipe_d[ST_J].qy     = '0;

    // restoring division: one quotient bit per stage, msb first
    for (int i = 0; i < QW; i++) begin
      pipe_d[ST_DV+i] = pipe_q[ST_DV+i-1];
      shx = {pipe_q[ST_DV+i-1].remx, pipe_q[ST_DV+i-1].dvx_lo[QW-1-i]};
      shy = {pipe_q[ST_DV+i-1].remy, pipe_q[ST_DV+i-1].dvy_lo[QW-1-i]};
      if (shx >= {1'b0, pipe_q[ST_DV+i-1].root}) begin
        pipe_d[ST_DV+i].remx          = LEN_W'(shx - {1'b0, pipe_q[ST_DV+i-1].root});
        pipe_d[ST_DV+i].qx[QW-1-i]    = 1'b1;
      end else begin
        pipe_d[ST_DV+i].remx          = shx[LEN_W-1:0];
      end
      if (shy >= {1'b0, pipe_q[ST_DV+i-1].root}) begin
        pipe_d[ST_DV+i].remy          = LEN_W'(shy - {1'b0, pipe_q[ST_DV+i-1].root});
        pipe_d[ST_DV+i].qy[QW-1-i]    = 1'b1;
      end else begin
        pipe_d[ST_DV+i].remy          = shy[LEN_W-1:0];
      end
    end

    // stage K: pick the local normal and depth
    pipe_d[ST_K] = pipe_q[ST_K-1];
    qsx = $signed({1'b0, pipe_q[ST_K-1].qx});
    qsy = $signed({1'b0, pipe_q[ST_K-1].qy});
    if (pipe_q[ST_K-1].near) begin
      pipe_d[ST_K].nx  = pipe_q[ST_K-1].near_nx;
      pipe_d[ST_K].ny  = pipe_q[ST_K-1].near_ny;
      pipe_d[ST_K].pen = pipe_q[ST_K-1].near_pen;
    end else begin
      pipe_d[ST_K].nx = pipe_q[ST_K-1].dfx[LW-1] ? -qsx : qsx;
      pipe_d[ST_K].ny = pipe_q[ST_K-1].dfy[LW-1] ? -qsy : qsy;
    end

    // stage L: normal rotation products
    pipe_d[ST_L]    = pipe_q[ST_K];
    pipe_d[ST_L].m1 = pipe_q[ST_K].c * pipe_q[ST_K].nx;
    pipe_d[ST_L].m2 = pipe_q[ST_K].s * pipe_q[ST_K].ny;
    pipe_d[ST_L].m3 = pipe_q[ST_K].s * pipe_q[ST_K].nx;
    pipe_d[ST_L].m4 = pipe_q[ST_K].c * pipe_q[ST_K].ny;

    // stage M: rounded sums
    pipe_d[ST_M] = pipe_q[ST_L];
    msx = (MW + 1)'(pipe_q[ST_L].m1) - (MW + 1)'(pipe_q[ST_L].m2) + MRND_HALF;
    msy = (MW + 1)'(pipe_q[ST_L].m3) + (MW + 1)'(pipe_q[ST_L].m4) + MRND_HALF;
    pipe_d[ST_M].rnx = msx[MW:TRIG_FRAC_BITS];
    pipe_d[ST_M].rny = msy[MW:TRIG_FRAC_BITS];

    // stage N: saturate, zero everything on a miss
    pipe_d[ST_N] = pipe_q[ST_M];
    if (pipe_q[ST_M].rnx[MRW-1:TRIG_W-1] == '0 || pipe_q[ST_M].rnx[MRW-1:TRIG_W-1] == '1) begin
      pipe_d[ST_N].wnx = pipe_q[ST_M].rnx[TRIG_W-1:0];
    end else begin
      pipe_d[ST_N].wnx = pipe_q[ST_M].rnx[MRW-1] ? {1'b1, {(TRIG_W-1){1'b0}}}
                                                 : {1'b0, {(TRIG_W-1){1'b1}}};
    end
    if (pipe_q[ST_M].rny[MRW-1:TRIG_W-1] == '0 || pipe_q[ST_M].rny[MRW-1:TRIG_W-1] == '1) begin
      pipe_d[ST_N].wny = pipe_q[ST_M].rny[TRIG_W-1:0];
    end else begin
      pipe_d[ST_N].wny = pipe_q[ST_M].rny[MRW-1] ? {1'b1, {(TRIG_W-1){1'b0}}}
                                                 : {1'b0, {(TRIG_W-1){1'b1}}};
    end
    if (pipe_q[ST_M].miss) begin
      pipe_d[ST_N].wnx = '0;
      pipe_d[ST_N].wny = '0;
      pipe_d[ST_N].pen = '0;
      pipe_d[ST_N].wx  = '0;
      pipe_d[ST_N].wy  = '0;
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTAGE-2:0], in_valid_i};
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NSTAGE; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  assign out_valid_o   = vld_q[ST_N];
  assign hit_o         = !pipe_q[ST_N].miss;
  assign normal_x_o    = pipe_q[ST_N].wnx;
  assign normal_y_o    = pipe_q[ST_N].wny;
  assign penetration_o = pipe_q[ST_N].pen;
  assign contact_x_o   = pipe_q[ST_N].wx;
  assign contact_y_o   = pipe_q[ST_N].wy;

  // a reported miss carries no normal and no depth
  `COC_ASSERT_IMPLIES(a_miss_zero, out_valid_o && !hit_o, normal_x_o == 0 && normal_y_o == 0 && penetration_o == 0)
  // a zero radius never reaches the root as a hit
  `COC_ASSERT_IMPLIES(a_zero_radius, vld_q[ST_I] && pipe_q[ST_I].r == 0, pipe_q[ST_I].miss)
  // on a hit the root stays below the radius
  `COC_ASSERT_IMPLIES(a_dist_lt_r, vld_q[ST_J] && !pipe_q[ST_J].miss, pipe_q[ST_J].root < pipe_q[ST_J].r)
  // the quotient of a unit normal never passes one
  `COC_ASSERT_IMPLIES(a_unit_q, vld_q[ST_K-1] && !pipe_q[ST_K-1].miss && !pipe_q[ST_K-1].near, pipe_q[ST_K-1].qx <= QW'(NORM_ONE) && pipe_q[ST_K-1].qy <= QW'(NORM_ONE))
  // an accepted transaction enters the first stage
  `COC_ASSERT_NEXT(a_enter, in_valid_i && !in_stall_o, vld_q[ST_A])

endmodule

`default_nettype wire

### sim/circle_obb_contact_unit_test.sv
`timescale 1ns / 1ps

module circle_obb_contact_unit_test;
  import coc_pkg::*;

  localparam int  N_RANDOM = 850;
  localparam int  TAIL     = 120;     // comfortably above the pipeline depth
  localparam longint ONE_N = 64'sd16384;

  // one circle/box pair as presented to the block
  typedef struct packed {
    logic signed [COORD_W-1:0] ccx;
    logic signed [COORD_W-1:0] ccy;
    logic        [LEN_W-1:0]   rad;
    logic signed [COORD_W-1:0] bcx;
    logic signed [COORD_W-1:0] bcy;
    logic signed [TRIG_W-1:0]  cs;
    logic signed [TRIG_W-1:0]  sn;
    logic        [LEN_W-1:0]   hx;
    logic        [LEN_W-1:0]   hy;
  } pair_t;

  // one contact result
  typedef struct packed {
    logic                      hit;
    logic signed [TRIG_W-1:0]  nx;
    logic signed [TRIG_W-1:0]  ny;
    logic        [LEN_W-1:0]   pen;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } contact_t;

  typedef struct packed {
    pair_t    p;
    bit       typed;    // expected result written out by hand
    contact_t e;
  } row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, out_stall_i;
  logic in_stall_o, out_valid_o;
  pair_t drv;
  logic hit_o;
  logic signed [TRIG_W-1:0]  normal_x_o, normal_y_o;
  logic        [LEN_W-1:0]   penetration_o;
  logic signed [COORD_W-1:0] contact_x_o, contact_y_o;

  contact_t pending_contacts[$];
  int  mismatches;
  bit  calm;     // no idling on either side while set

  circle_obb_contact_unit uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .circle_center_x_i(drv.ccx), .circle_center_y_i(drv.ccy), .radius_i(drv.rad),
    .box_center_x_i(drv.bcx), .box_center_y_i(drv.bcy),
    .box_cos_i(drv.cs), .box_sin_i(drv.sn),
    .half_x_i(drv.hx), .half_y_i(drv.hy),
    .out_valid_o, .out_stall_i,
    .hit_o, .normal_x_o, .normal_y_o, .penetration_o, .contact_x_o, .contact_y_o
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // generous overall limit
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // v / 2^14 to nearest, ties toward +inf
  function automatic longint rot_round(longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic longint sat_to(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // unit normal component, half away from zero
  function automatic longint unit_comp(longint d, longint root);
    longint q;
    q = ((mag(d) <<< 14) + root / 2) / root;
    return d < 0 ? -q : q;
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    longint c, s, r, hx, hy, dx, dy, lx, ly, clx, cly, gx, gy;
    longint root, nx, ny, pen, fx, fy;
    longint unsigned dsq, rsq, n, res, b;
    contact_t e;
    e  = '0;
    c  = p.cs;
    s  = p.sn;
    r  = longint'({1'b0, p.rad});
    hx = longint'({1'b0, p.hx});
    hy = longint'({1'b0, p.hy});
    dx = longint'(p.ccx) - longint'(p.bcx);
    dy = longint'(p.ccy) - longint'(p.bcy);
    // circle centre in the box frame, clamped to the box
    lx = rot_round(c * dx + s * dy);
    ly = rot_round(c * dy - s * dx);
    clx = lx < -hx ? -hx : (lx > hx ? hx : lx);
    cly = ly < -hy ? -hy : (ly > hy ? hy : ly);
    gx = lx - clx;
    gy = ly - cly;
    if (mag(gx) >= r || mag(gy) >= r) return e;
    dsq = gx * gx + gy * gy;
    rsq = r * r;
    if (dsq >= rsq) return e;
    // floor square root, two bits per step
    n = dsq;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    root = longint'(res);
    if (root * 1000000 < 65536) begin
      // centre inside the box: push out through the nearer face
      fx = hx - mag(lx);
      fy = hy - mag(ly);
      if (fx < fy) begin
        nx = lx > 0 ? ONE_N : -ONE_N;
        ny = 0;
        pen = r + fx;
      end else begin
        nx = 0;
        ny = ly > 0 ? ONE_N : -ONE_N;
        pen = r + fy;
      end
    end else begin
      nx = unit_comp(gx, root);
      ny = unit_comp(gy, root);
      pen = r - root;
    end
    e.hit = 1'b1;
    e.pen = LEN_W'(sat_to(pen, 0, 64'sh7FFFFFFF));
    e.nx  = TRIG_W'(sat_to(rot_round(c * nx - s * ny), -32768, 32767));
    e.ny  = TRIG_W'(sat_to(rot_round(s * nx + c * ny), -32768, 32767));
    e.px  = COORD_W'(sat_to(longint'(p.bcx) + rot_round(c * clx - s * cly),
                            -64'sh80000000, 64'sh7FFFFFFF));
    e.py  = COORD_W'(sat_to(longint'(p.bcy) + rot_round(s * clx + c * cly),
                            -64'sh80000000, 64'sh7FFFFFFF));
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic row_t mk(longint ccx, longint ccy, longint rad, longint bcx,
                              longint bcy, longint cs, longint sn, longint hx,
                              longint hy, bit typed = 0, contact_t e = '0);
    row_t t;
    t.p = '{COORD_W'(ccx), COORD_W'(ccy), LEN_W'(rad), COORD_W'(bcx), COORD_W'(bcy),
            TRIG_W'(cs), TRIG_W'(sn), LEN_W'(hx), LEN_W'(hy)};
    t.typed = typed;
    t.e = e;
    return t;
  endfunction

  // mostly pairs that sit close to each other, with a rotation of unit length;
  // the rest is noise over every bit of every field
  function automatic pair_t random_pair();
    pair_t p;
    int k;
    longint c, reach;
    p = pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom});
    if ($urandom_range(0, 99) < 75) begin
      c = longint'($urandom_range(0, 32768)) - 16384;
      p.cs = TRIG_W'(c);
      p.sn = TRIG_W'($rtoi($sqrt(268435456.0 - c * c)) * ($urandom_range(0, 1) ? 1 : -1));
      k = $urandom_range(4, 28);
      p.hx = LEN_W'($urandom_range(0, 1 << k));
      p.hy = LEN_W'($urandom_range(0, 1 << k));
      p.rad = LEN_W'($urandom_range(0, 1 << k));
      if ($urandom_range(0, 9) < 8) begin
        p.bcx = $signed($urandom) >>> $urandom_range(0, 8);
        p.bcy = $signed($urandom) >>> $urandom_range(0, 8);
      end
      reach = (longint'(1) << (k + 2));
      p.ccx = COORD_W'(sat_to(longint'(p.bcx) + longint'($urandom_range(0, 2 * reach)) - reach,
                              -64'sh80000000, 64'sh7FFFFFFF));
      p.ccy = COORD_W'(sat_to(longint'(p.bcy) + longint'($urandom_range(0, 2 * reach)) - reach,
                              -64'sh80000000, 64'sh7FFFFFFF));
    end
    return p;
  endfunction

  row_t stim_table[$];

  // hands one transaction to the block and logs what it must answer
  task automatic send_pair(pair_t p, bit typed, contact_t e);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    drv <= p;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_contacts.push_back(typed ? e : predict_contact(p));
  endtask

  initial begin
    contact_t miss, e;
    in_valid_i = 1'b0;
    drv = '0;
    calm = 1'b0;
    miss = '0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    // zero radius never hits, even dead centre
    stim_table.push_back(mk(0, 0, 0, 0, 0, 16384, 0, 100, 100, 1, miss));
    // far apart at opposite coordinate extremes
    stim_table.push_back(mk(64'sh7FFFFFFF, 64'sh7FFFFFFF, 65536, -64'sh80000000,
                            -64'sh80000000, 16384, 0, 0, 0, 1, miss));
    // centre inside, the x face nearer
    e = '{1'b1, -16'sd16384, 16'sd0, 31'(11 << 16), 32'sd0, 32'sd0};
    stim_table.push_back(mk(0, 0, 1 << 16, 0, 0, 16384, 0, 10 << 16, 20 << 16, 1, e));
    // centre inside, the y face nearer
    e = '{1'b1, 16'sd0, -16'sd16384, 31'(11 << 16), 32'sd0, 32'sd0};
    stim_table.push_back(mk(0, 0, 1 << 16, 0, 0, 16384, 0, 20 << 16, 10 << 16, 1, e));
    // inside and off centre, both signs
    stim_table.push_back(mk(3 << 16, -2 << 16, 1 << 16, 0, 0, 16384, 0, 10 << 16, 10 << 16));
    stim_table.push_back(mk(-5 << 16, 7 << 16, 1 << 16, 0, 0, 0, 16384, 10 << 16, 8 << 16));
    // just outside a face, a corner, and just too far
    stim_table.push_back(mk(11 << 16, 0, 2 << 16, 0, 0, 16384, 0, 10 << 16, 10 << 16));
    stim_table.push_back(mk(11 << 16, 11 << 16, 2 << 16, 0, 0, 16384, 0, 10 << 16, 10 << 16));
    stim_table.push_back(mk(12 << 16, 0, 2 << 16, 0, 0, 16384, 0, 10 << 16, 10 << 16));
    // rotated boxes
    stim_table.push_back(mk(9 << 16, 9 << 16, 4 << 16, 0, 0, 11585, 11585, 10 << 16, 2 << 16));
    stim_table.push_back(mk(-9 << 16, 3 << 16, 3 << 16, 1 << 16, 0, -16384, 0,
                            8 << 16, 2 << 16));
    stim_table.push_back(mk(2 << 16, -13 << 16, 5 << 16, 0, 0, 0, -16384, 10 << 16, 4 << 16));
    // all lengths at their maximum: penetration saturates
    stim_table.push_back(mk(0, 0, 64'h7FFFFFFF, 0, 0, 16384, 0, 64'h7FFFFFFF,
                            64'h7FFFFFFF));
    stim_table.push_back(mk(64'sh7FFFFFFF, 64'sh7FFFFFFF, 64'h7FFFFFFF, 64'sh7FFFFFFF,
                            64'sh7FFFFFFF, 16384, 16384, 64'h7FFFFFFF, 64'h7FFFFFFF));
    // contact point beyond the coordinate range
    stim_table.push_back(mk(64'sh7FFFFFFF, -64'sh80000000, 64'h40000000, 64'sh70000000,
                            -64'sh70000000, 11585, -11585, 64'h7FFFFFFF, 64'h7FFFFFFF));
    // cos and sin out of range, normal saturates
    stim_table.push_back(mk(20 << 16, 1 << 16, 8 << 16, 0, 0, 32767, -32768,
                            16 << 16, 16 << 16));
    stim_table.push_back(mk(-20 << 16, -1 << 16, 8 << 16, 0, 0, -32768, 32767,
                            16 << 16, 16 << 16));
    // degenerate box, a point
    stim_table.push_back(mk(1 << 16, 1 << 16, 2 << 16, 0, 0, 16384, 0, 0, 0));

    foreach (stim_table[i]) send_pair(stim_table[i].p, stim_table[i].typed, stim_table[i].e);

    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 300 && i < 450);
      send_pair(random_pair(), 1'b0, miss);
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    // drain, then let the pipeline run empty
    while (pending_contacts.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  initial out_stall_i = 1'b0;

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 12);
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // each accepted result transaction against the oldest expectation
  always @(posedge clk_i) begin
    contact_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_contacts.size() == 0) begin
        report_mismatch("unexpected result, hit", hit_o, 0);
      end else begin
        want = pending_contacts.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
        if (normal_x_o !== want.nx) report_mismatch("normal_x", normal_x_o, want.nx);
        if (normal_y_o !== want.ny) report_mismatch("normal_y", normal_y_o, want.ny);
        if (penetration_o !== want.pen)
          report_mismatch("penetration", penetration_o, want.pen);
        if (contact_x_o !== want.px) report_mismatch("contact_x", contact_x_o, want.px);
        if (contact_y_o !== want.py) report_mismatch("contact_y", contact_y_o, want.py);
      end
    end
  end

endmodule
